// File: hdl/pfcs_pkg.sv
// shared types, widths and codes for the palette fade cycle sequencer
// no dependencies; imported by pfcs_div and the top level
package pfcs_pkg;

	localparam int PALETTE_DEPTH_DEF = 16;

	localparam int NOW_W     = 32;
	localparam int CH_W      = 8;
	localparam int POS_W     = 4;
	localparam int CFG_IDX_W = 3;
	localparam int PH_W      = 18;            // one phase in ms, at most 255000
	localparam int TOT_W     = 20;            // sum of three phases
	localparam int PN_W      = 2 * CH_W + 10; // units * scale * 1000
	localparam int DVD_W     = 32;
	localparam int DSR_W     = 20;
	localparam int COLOR_W   = 3 * CH_W;

	localparam logic [9:0]      MS_PER_S    = 10'd1000;

	// floor(x / 255) is (x * RECIP_255) >> RECIP_SH for every x below 2^26
	localparam int RCP_W    = 27;
	localparam int RECIP_SH = 34;
	localparam logic [RCP_W-1:0] RECIP_255 = 27'd67372037;

	localparam logic [CH_W-1:0] STEM_RST    = 8'd128;
	localparam logic [CH_W-1:0] FADE_IN_RST = 8'd50;
	localparam logic [CH_W-1:0] HOLD_RST    = 8'd150;
	localparam logic [CH_W-1:0] FADE_OUT_RST = 8'd50;
	localparam logic [CH_W-1:0] SCALE_RST   = 8'd1;

	typedef enum logic [1:0] {
		OP_START  = 2'd0,
		OP_APPEND = 2'd1,
		OP_FRAME  = 2'd2
	} opcode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_STEM     = 3'd0,
		CFG_FADE_IN  = 3'd1,
		CFG_HOLD     = 3'd2,
		CFG_FADE_OUT = 3'd3,
		CFG_SCALE    = 3'd4
	} cfg_reg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PH_MUL,
		ST_PH_LOAD,
		ST_PH_WAIT,
		ST_TOT,
		ST_MOD_LOAD,
		ST_MOD_WAIT,
		ST_RD,
		ST_RD_WAIT,
		ST_ENV_LOAD,
		ST_ENV_WAIT,
		ST_OUT
	} pfcs_state_t;

	typedef struct packed {
		logic [1:0]       opcode;
		logic [NOW_W-1:0] now_ms;
		logic [CH_W-1:0]  in_hue;
		logic [CH_W-1:0]  in_sat;
		logic [CH_W-1:0]  in_val;
	} pfcs_in_t;

	typedef struct packed {
		logic             shown;
		logic [CH_W-1:0]  out_hue;
		logic [CH_W-1:0]  out_sat;
		logic [CH_W-1:0]  out_val;
		logic [CH_W-1:0]  stem_out;
		logic [POS_W-1:0] palette_pos;
	} pfcs_out_t;

	typedef struct packed {
		logic             start;
		logic [DVD_W-1:0] dividend;
		logic [DSR_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             busy;
		logic             done;
		logic [DVD_W-1:0] quot;
		logic [DSR_W-1:0] rem;
	} div_rsp_t;

endpackage

// File: hdl/pfcs_div.sv
// shared restoring divider, one quotient bit per cycle
// depends on pfcs_pkg
module pfcs_div (
	input  logic                clk,
	input  logic                arst_n,
	input  pfcs_pkg::div_req_t  req,
	output pfcs_pkg::div_rsp_t  rsp
);
	import pfcs_pkg::*;

	localparam int CNT_W = $clog2(DVD_W);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DVD_W-1:0] quot_q;
	logic [DSR_W-1:0] rem_q;
	logic [DSR_W-1:0] dsr_q;
	logic [DSR_W:0]   trial;
	logic [DSR_W:0]   diff;
	logic             fits;

	// dividend bits shift out of quot_q as quotient bits shift in
	assign trial = {rem_q, quot_q[DVD_W-1]};
	assign diff  = trial - {1'b0, dsr_q};
	assign fits  = trial >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DVD_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quot_q <= req.dividend;
			rem_q  <= '0;
			dsr_q  <= req.divisor;
		end else if (busy_q) begin
			quot_q <= {quot_q[DVD_W-2:0], fits};
			rem_q  <= fits ? diff[DSR_W-1:0] : trial[DSR_W-1:0];
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.quot = quot_q;
	assign rsp.rem  = rem_q;

endmodule

// File: hdl/pfcs_palette_ram.sv
// palette store, one write port and one registered read port
// depends on pfcs_pkg for nothing; sized by parameters from the top level
module pfcs_palette_ram #(
	parameter int DEPTH = 16,
	parameter int AW    = 4,
	parameter int DW    = 24
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);
	logic [DW-1:0] mem_q [DEPTH];
	logic [DW-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// File: hdl/palette_fade_cycle_sequencer_unit.sv
// top level: palette fade cycle sequencer, sequencer around a shared divider
// depends on pfcs_pkg, pfcs_div, pfcs_palette_ram
//
//   channel | direction | handshake         | payload
//   in      | into unit | in_valid/in_ready | in_data (pfcs_in_t)
//   out     | from unit | out_valid/out_ready | out_data (pfcs_out_t)
//   cfg     | into unit | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// start and append requests are handled in the idle state; a frame on an empty palette goes straight to the output step
// a frame in a fade phase makes three passes through the 1-bit-per-cycle divider
// (cycle modulo, value and stem fades); in the hold phase only the modulo pass, with zero cycle length none
// the first frame on a non-empty palette after reset or after a timing register write
// also recomputes the three phase lengths by reciprocal multiplication
// reset is asynchronous, active low; a pending result holds in the output register
// while out_ready is low, and the next request is taken meanwhile
module palette_fade_cycle_sequencer_unit #(
	parameter int PALETTE_DEPTH = pfcs_pkg::PALETTE_DEPTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  pfcs_pkg::pfcs_in_t                in_data,
	output logic                              out_valid,
	input  logic                              out_ready,
	output pfcs_pkg::pfcs_out_t               out_data,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [pfcs_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [pfcs_pkg::CH_W-1:0]         cfg_data
);
	import pfcs_pkg::*;

	localparam int IDX_W = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
	localparam int CNT_W = $clog2(PALETTE_DEPTH + 1);
	localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(PALETTE_DEPTH);

	pfcs_state_t state_q, state_d;

	logic [CH_W-1:0]  stem_q, fin_units_q, hold_units_q, fout_units_q, scale_q;
	logic [PH_W-1:0]  fin_ms_q, hold_ms_q, fout_ms_q;
	logic             stale_q;
	logic [CNT_W-1:0] count_q;
	logic [IDX_W-1:0] idx_q;
	logic [NOW_W-1:0] start_q;
	logic             out_valid_q;
	pfcs_out_t        out_q;

	logic [1:0]       ph_sel_q;
	logic             env_sel_q;
	logic [NOW_W-1:0] now_q;
	logic [TOT_W-1:0] total_q;
	logic [TOT_W-1:0] e_q;
	logic [2*CH_W-1:0] prod_q;
	logic [PN_W-1:0]  ph_num_q;
	logic [PH_W-1:0]  num_q;
	logic [PH_W-1:0]  env_dsr_q;
	logic [CH_W-1:0]  hue_q, sat_q, base_q, val_q, stemv_q;
	logic             shown_q;

	div_req_t         div_req;
	div_rsp_t         div_rsp;

	logic             in_acc;
	logic             frame_go;
	logic             append_we;
	logic             out_load;
	logic [CH_W-1:0]  units_sel;
	logic [PN_W-1:0]  ph_num;
	logic [PN_W+RCP_W-1:0] ph_prod;
	logic [PH_W-1:0]  ph_ms;
	logic [CH_W-1:0]  env_base;
	logic [CH_W+PH_W-1:0] env_prod;
	logic [TOT_W-1:0] total_sum;
	logic [TOT_W-1:0] fin_end;
	logic [TOT_W-1:0] hold_end;
	logic             in_fade_in;
	logic             flat;
	logic [NOW_W-1:0] elapsed;
	logic [IDX_W-1:0] idx_nxt;
	logic [COLOR_W-1:0] rd_color;

	assign in_acc    = in_valid && in_ready;
	assign frame_go  = in_acc && (in_data.opcode == OP_FRAME);
	assign append_we = in_acc && (in_data.opcode == OP_APPEND) && (count_q < DEPTH_C);
	assign cfg_ready = 1'b1;
	assign out_load  = (state_q == ST_OUT) && (!out_valid_q || out_ready);

	always_comb begin
		case (ph_sel_q)
			2'd0:    units_sel = fin_units_q;
			2'd1:    units_sel = hold_units_q;
			default: units_sel = fout_units_q;
		endcase
	end

	assign ph_num    = PN_W'(prod_q) * PN_W'(MS_PER_S);
	// division by 255 as a reciprocal multiply
	assign ph_prod   = (PN_W+RCP_W)'(ph_num_q) * (PN_W+RCP_W)'(RECIP_255);
	assign ph_ms     = ph_prod[RECIP_SH +: PH_W];
	assign env_base  = env_sel_q ? stem_q : base_q;
	assign env_prod  = (CH_W+PH_W)'(env_base) * (CH_W+PH_W)'(num_q);
	assign total_sum = TOT_W'(fin_ms_q) + TOT_W'(hold_ms_q) + TOT_W'(fout_ms_q);
	assign fin_end   = TOT_W'(fin_ms_q);
	assign hold_end  = TOT_W'(fin_ms_q) + TOT_W'(hold_ms_q);
	assign in_fade_in = e_q < fin_end;
	// zero cycle length or hold phase: full level, no envelope division
	assign flat      = (total_q == '0) || (!in_fade_in && (e_q < hold_end));
	assign elapsed   = now_q - start_q;
	assign idx_nxt   = ((CNT_W'(idx_q) + CNT_W'(1)) == count_q) ? '0 : idx_q + IDX_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d          = state_q;
		in_ready         = 1'b0;
		div_req.start    = 1'b0;
		div_req.dividend = '0;
		div_req.divisor  = '0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (frame_go) begin
					if (count_q == '0) begin
						state_d = ST_OUT;
					end else if (stale_q) begin
						state_d = ST_PH_MUL;
					end else begin
						state_d = ST_TOT;
					end
				end
			end
			ST_PH_MUL: begin
				state_d = ST_PH_LOAD;
			end
			ST_PH_LOAD: begin
				state_d = ST_PH_WAIT;
			end
			ST_PH_WAIT: begin
				state_d = (ph_sel_q == 2'd2) ? ST_TOT : ST_PH_MUL;
			end
			ST_TOT: begin
				state_d = ST_MOD_LOAD;
			end
			ST_MOD_LOAD: begin
				if (total_q == '0) begin
					state_d = ST_RD;
				end else begin
					div_req.start    = 1'b1;
					div_req.dividend = elapsed;
					div_req.divisor  = DSR_W'(total_q);
					state_d          = ST_MOD_WAIT;
				end
			end
			ST_MOD_WAIT: begin
				if (div_rsp.done) begin
					state_d = ST_RD;
				end
			end
			ST_RD: begin
				state_d = ST_RD_WAIT;
			end
			ST_RD_WAIT: begin
				state_d = flat ? ST_OUT : ST_ENV_LOAD;
			end
			ST_ENV_LOAD: begin
				div_req.start    = 1'b1;
				div_req.dividend = DVD_W'(env_prod);
				div_req.divisor  = DSR_W'(env_dsr_q);
				state_d          = ST_ENV_WAIT;
			end
			ST_ENV_WAIT: begin
				if (div_rsp.done) begin
					state_d = env_sel_q ? ST_OUT : ST_ENV_LOAD;
				end
			end
			ST_OUT: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// control and architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stem_q       <= STEM_RST;
			fin_units_q  <= FADE_IN_RST;
			hold_units_q <= HOLD_RST;
			fout_units_q <= FADE_OUT_RST;
			scale_q      <= SCALE_RST;
			stale_q      <= 1'b1;
			count_q      <= '0;
			idx_q        <= '0;
			start_q      <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					CFG_STEM: begin
						stem_q <= cfg_data;
					end
					CFG_FADE_IN: begin
						fin_units_q <= cfg_data;
						stale_q     <= 1'b1;
					end
					CFG_HOLD: begin
						hold_units_q <= cfg_data;
						stale_q      <= 1'b1;
					end
					CFG_FADE_OUT: begin
						fout_units_q <= cfg_data;
						stale_q      <= 1'b1;
					end
					CFG_SCALE: begin
						scale_q <= cfg_data;
						stale_q <= 1'b1;
					end
					default: begin
					end
				endcase
			end
			if (in_acc && (in_data.opcode == OP_START)) begin
				count_q <= '0;
				idx_q   <= '0;
				start_q <= in_data.now_ms;
			end
			if (append_we) begin
				count_q <= count_q + CNT_W'(1);
			end
			if (frame_go && (count_q != '0) && (CNT_W'(idx_q) >= count_q)) begin
				idx_q <= '0;
			end
			if ((state_q == ST_PH_WAIT) && (ph_sel_q == 2'd2)) begin
				stale_q <= 1'b0;
			end
			// a full cycle has passed: advance and realign to the boundary
			if ((state_q == ST_MOD_WAIT) && div_rsp.done && (div_rsp.quot != '0)) begin
				idx_q   <= idx_nxt;
				start_q <= now_q - NOW_W'(div_rsp.rem);
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// working registers of one frame request
	always_ff @(posedge clk) begin
		if (frame_go) begin
			now_q    <= in_data.now_ms;
			ph_sel_q <= 2'd0;
			shown_q  <= (count_q != '0);
			hue_q    <= '0;
			sat_q    <= '0;
			val_q    <= '0;
			stemv_q  <= '0;
		end
		if (state_q == ST_PH_MUL) begin
			prod_q <= (2*CH_W)'(units_sel) * (2*CH_W)'(scale_q);
		end
		if (state_q == ST_PH_LOAD) begin
			ph_num_q <= ph_num;
		end
		if (state_q == ST_PH_WAIT) begin
			case (ph_sel_q)
				2'd0:    fin_ms_q  <= ph_ms;
				2'd1:    hold_ms_q <= ph_ms;
				default: fout_ms_q <= ph_ms;
			endcase
			ph_sel_q <= ph_sel_q + 2'd1;
		end
		if (state_q == ST_TOT) begin
			total_q <= total_sum;
		end
		if ((state_q == ST_MOD_WAIT) && div_rsp.done) begin
			e_q <= div_rsp.rem;
		end
		if (state_q == ST_RD_WAIT) begin
			hue_q     <= rd_color[3*CH_W-1:2*CH_W];
			sat_q     <= rd_color[2*CH_W-1:CH_W];
			base_q    <= rd_color[CH_W-1:0];
			env_sel_q <= 1'b0;
			if (flat) begin
				val_q   <= rd_color[CH_W-1:0];
				stemv_q <= stem_q;
			end else if (in_fade_in) begin
				num_q     <= e_q[PH_W-1:0];
				env_dsr_q <= fin_ms_q;
			end else begin
				// time left in the fade out
				num_q     <= PH_W'(total_q - e_q);
				env_dsr_q <= fout_ms_q;
			end
		end
		if ((state_q == ST_ENV_WAIT) && div_rsp.done) begin
			if (env_sel_q) begin
				stemv_q <= div_rsp.quot[CH_W-1:0];
			end else begin
				val_q     <= div_rsp.quot[CH_W-1:0];
				env_sel_q <= 1'b1;
			end
		end
		if (out_load) begin
			out_q.shown       <= shown_q;
			out_q.out_hue     <= hue_q;
			out_q.out_sat     <= sat_q;
			out_q.out_val     <= val_q;
			out_q.stem_out    <= stemv_q;
			out_q.palette_pos <= shown_q ? POS_W'(idx_q) : '0;
		end
	end

	pfcs_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	pfcs_palette_ram #(
		.DEPTH (PALETTE_DEPTH),
		.AW    (IDX_W),
		.DW    (COLOR_W)
	) u_ram (
		.clk   (clk),
		.we    (append_we),
		.waddr (count_q[IDX_W-1:0]),
		.wdata ({in_data.in_hue, in_data.in_sat, in_data.in_val}),
		.raddr (idx_q),
		.rdata (rd_color)
	);

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= DEPTH_C)
		else $error("palette count above depth");

	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RD) |-> (CNT_W'(idx_q) < count_q))
		else $error("palette read beyond filled entries");

	a_div_free: assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |-> !div_rsp.busy)
		else $error("divider started while busy");

	a_phases_fresh: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_TOT) |-> !stale_q)
		else $error("cycle length taken from stale phase lengths");

	a_out_from_seq: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_OUT))
		else $error("result raised outside output step");

endmodule
